/* src/tpr_pkg.sv */
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared constants and types of the passive TCP responder: table size,
// control-bit patterns, reply actions, connection states and the table ports.
// ----------------------------------------------------------------------------
package tpr_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // TCP control-bit patterns
   localparam logic [5:0] FLG_NONE   = 6'h00;
   localparam logic [5:0] FLG_SYN    = 6'h02;
   localparam logic [5:0] FLG_ACK    = 6'h10;
   localparam logic [5:0] FLG_PSHACK = 6'h18;
   localparam logic [5:0] FLG_FINACK = 6'h11;
   localparam logic [5:0] FLG_SYNACK = 6'h12;

   // reply actions
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_REPLY     = 3'd1;
   localparam logic [2:0] ACT_FIN_PASS  = 3'd2;
   localparam logic [2:0] ACT_ACK_CLOSE = 3'd3;
   localparam logic [2:0] ACT_ACK_STRIP = 3'd4;

   // connection states
   localparam logic [1:0] CS_CLOSED  = 2'd0;
   localparam logic [1:0] CS_ESTAB   = 2'd1;
   localparam logic [1:0] CS_SYNRCVD = 2'd2;

   // configuration register indexes
   localparam logic REG_LOCAL_IP   = 1'b0;
   localparam logic REG_LOCAL_PORT = 1'b1;

   typedef struct packed {
      logic [31:0] peer_addr;
      logic [15:0] peer_port;
      logic [1:0]  conn_state;
   } tbl_entry_type;

   typedef struct packed {
      logic        peer_we;
      logic        expect_we;
      logic        own_we;
      logic        state_we;
      logic [31:0] peer_addr;
      logic [15:0] peer_port;
      logic [47:0] peer_hw;
      logic [1:0]  conn_state;
      logic [31:0] expect_seq;
      logic [31:0] own_seq;
   } tbl_wr_type;

endpackage

/* src/tpr_conn_table.sv */
// ----------------------------------------------------------------------------
// tpr_conn_table
// Connection table in flip-flops: one shared read/write pointer, per-field
// write enables, all entries cleared by reset.
// ----------------------------------------------------------------------------
module tpr_conn_table
   import tpr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] ptr,
   input  tbl_wr_type       wr,
   output tbl_entry_type    entry
);

   logic [31:0] peer_addr_ff  [TABLE_ENTRIES];
   logic [15:0] peer_port_ff  [TABLE_ENTRIES];
   logic [47:0] peer_hw_ff    [TABLE_ENTRIES];
   logic [1:0]  conn_state_ff [TABLE_ENTRIES];
   logic [31:0] expect_seq_ff [TABLE_ENTRIES];
   logic [31:0] own_seq_ff    [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            peer_addr_ff[i]  <= '0;
            peer_port_ff[i]  <= '0;
            peer_hw_ff[i]    <= '0;
            conn_state_ff[i] <= CS_CLOSED;
            expect_seq_ff[i] <= '0;
            own_seq_ff[i]    <= '0;
         end
      end else begin
         if (wr.peer_we) begin
            peer_addr_ff[ptr] <= wr.peer_addr;
            peer_port_ff[ptr] <= wr.peer_port;
            peer_hw_ff[ptr]   <= wr.peer_hw;
         end
         if (wr.expect_we) begin
            expect_seq_ff[ptr] <= wr.expect_seq;
         end
         if (wr.own_we) begin
            own_seq_ff[ptr] <= wr.own_seq;
         end
         if (wr.state_we) begin
            conn_state_ff[ptr] <= wr.conn_state;
         end
      end
   end

   assign entry.peer_addr  = peer_addr_ff[ptr];
   assign entry.peer_port  = peer_port_ff[ptr];
   assign entry.conn_state = conn_state_ff[ptr];

endmodule

/* src/tcp_passive_responder.sv */
// ----------------------------------------------------------------------------
// tcp_passive_responder
// Passive TCP responder: filters parsed segment headers, tracks connections
// and builds one reply header per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one parsed segment header; it is taken when req_valid is
//   high and req_stall low. rsp_* carries exactly one result per request,
//   also for dropped segments (action none, all fields zero). local_ip and
//   local_port are written over the APB port at byte addresses 0 and 4.
//   Flow: one request at a time. After acceptance come the filter state, a
//   table scan of one entry per cycle (stops at the first peer match or at
//   the last entry), the execute state with the shared sequence adder, and
//   the output state that presents the result. A filtered segment goes from
//   the filter state straight to the output state, as does a segment that
//   finds no peer match and no free entry. The next request is taken in the
//   cycle after the result is taken. The sequential entry scan sets the rate.
//   Reset clears the configuration, the whole connection table and the
//   sequencer state at once; no clearing pass follows.
//   While rsp_stall is high the result holds and req_stall stays high.
// ----------------------------------------------------------------------------
module tcp_passive_responder
   import tpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [47:0] req_peer_mac_in,
   input  logic [5:0]  req_flags_in,
   input  logic [3:0]  req_header_words,
   input  logic [31:0] req_seq_in,
   input  logic [31:0] req_ack_in,
   input  logic [10:0] req_payload_len,
   input  logic        req_fin_resend,
   input  logic [31:0] req_random_isn,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [2:0]  rsp_conn_index,
   output logic [5:0]  rsp_out_flags,
   output logic [31:0] rsp_out_seq,
   output logic [31:0] rsp_out_ack,
   output logic [31:0] rsp_out_dst_ip,
   output logic [15:0] rsp_out_src_port,
   output logic [15:0] rsp_out_dst_port,
   output logic        rsp_deliver_data,
   output logic [3:0]  rsp_out_header_words,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  conn_index;
      logic [5:0]  out_flags;
      logic [31:0] out_seq;
      logic [31:0] out_ack;
      logic [31:0] out_dst_ip;
      logic [15:0] out_src_port;
      logic [15:0] out_dst_port;
      logic        deliver_data;
      logic [3:0]  out_header_words;
   } rsp_type;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   // configuration
   logic [31:0] local_ip_ff,   local_ip_in;
   logic [15:0] local_port_ff, local_port_in;
   logic        cfg_we;

   // sequencer
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             free_seen_ff, free_seen_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             accept;
   logic             ptr_last;

   // held request
   logic [31:0] src_ip_ff, dst_ip_ff, seq_ff, ack_ff, isn_ff;
   logic [15:0] sport_ff, dst_port_ff;
   logic [47:0] mac_ff;
   logic [5:0]  flags_ff;
   logic [3:0]  hw_ff;
   logic [10:0] plen_ff;
   logic        resend_ff;

   // result
   rsp_type res_ff, res_in;
   rsp_type res_exec;

   // table
   tbl_entry_type entry;
   tbl_wr_type    wr;

   logic [31:0]  key_ip;
   logic [15:0]  key_port;
   logic         key_hit;
   logic [5:0]   eff_flags;
   logic [31:0]  addend;
   logic [31:0]  seq_sum;
   logic [IDX_W+2:0] idx_ext;

   // ---------------------------------------------------------------- config
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   always_comb begin
      local_ip_in   = local_ip_ff;
      local_port_in = local_port_ff;
      if (cfg_we) begin
         case (paddr[2])
            REG_LOCAL_IP:   local_ip_in   = pwdata;
            REG_LOCAL_PORT: local_port_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LOCAL_IP:   prdata = local_ip_ff;
         REG_LOCAL_PORT: prdata = {16'h0000, local_port_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff   <= '0;
         local_port_ff <= '0;
      end else begin
         local_ip_ff   <= local_ip_in;
         local_port_ff <= local_port_in;
      end
   end

   // ---------------------------------------------------------------- request
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         src_ip_ff   <= req_src_ip;
         dst_ip_ff   <= req_dst_ip;
         sport_ff    <= req_src_port;
         dst_port_ff <= req_dst_port;
         mac_ff      <= req_peer_mac_in;
         flags_ff    <= req_flags_in;
         hw_ff       <= req_header_words;
         seq_ff      <= req_seq_in;
         ack_ff      <= req_ack_in;
         plen_ff     <= req_payload_len;
         resend_ff   <= req_fin_resend;
         isn_ff      <= req_random_isn;
      end
   end

   // ---------------------------------------------------------------- table
   tpr_conn_table u_table (
      .clock (clock),
      .reset (reset),
      .ptr   (ptr_ff),
      .wr    (wr),
      .entry (entry)
   );

   // resend looks up the peer by the destination fields
   assign key_ip   = resend_ff ? dst_ip_ff   : src_ip_ff;
   assign key_port = resend_ff ? dst_port_ff : sport_ff;
   assign key_hit  = (entry.peer_addr == key_ip) && (entry.peer_port == key_port);
   assign ptr_last = (ptr_ff == IDX_W'(TABLE_ENTRIES - 1));

   assign eff_flags = resend_ff ? FLG_FINACK : flags_ff;
   assign idx_ext   = {3'b000, ptr_ff};

   // shared sequence adder
   always_comb begin
      case (eff_flags)
         FLG_SYN, FLG_FINACK: addend = 32'd1;
         default:             addend = {21'd0, plen_ff};
      endcase
   end
   assign seq_sum = seq_ff + addend;

   // ---------------------------------------------------------------- execute
   always_comb begin
      res_exec                  = '0;
      res_exec.out_dst_ip       = src_ip_ff;
      res_exec.out_src_port     = local_port_ff;
      res_exec.out_dst_port     = sport_ff;
      res_exec.out_header_words = hw_ff;
      res_exec.out_ack          = seq_sum;
      res_exec.out_seq          = ack_ff;

      wr            = '0;
      wr.peer_addr  = src_ip_ff;
      wr.peer_port  = sport_ff;
      wr.peer_hw    = mac_ff;
      wr.expect_seq = seq_sum;
      wr.own_seq    = ack_ff;
      wr.conn_state = CS_CLOSED;

      case (eff_flags)
         FLG_SYN: begin
            res_exec.out_seq   = isn_ff;
            res_exec.out_flags = FLG_SYNACK;
            res_exec.action    = ACT_REPLY;
            wr.peer_we         = 1'b1;
            wr.expect_we       = 1'b1;
            wr.state_we        = 1'b1;
            wr.conn_state      = CS_SYNRCVD;
         end
         FLG_ACK: begin
            if (entry.conn_state != CS_CLOSED) begin
               wr.expect_we = 1'b1;
               wr.own_we    = 1'b1;
               if (entry.conn_state == CS_ESTAB) begin
                  if (plen_ff != '0) begin
                     res_exec.out_flags    = FLG_ACK;
                     res_exec.deliver_data = 1'b1;
                     res_exec.action       = ACT_REPLY;
                  end
               end else if (entry.conn_state == CS_SYNRCVD) begin
                  wr.state_we   = 1'b1;
                  wr.conn_state = CS_ESTAB;
               end
            end
         end
         FLG_PSHACK: begin
            wr.expect_we       = 1'b1;
            wr.own_we          = 1'b1;
            res_exec.out_flags = FLG_ACK;
            if (plen_ff != '0) begin
               res_exec.deliver_data = 1'b1;
               res_exec.action       = ACT_ACK_STRIP;
            end else begin
               res_exec.action = ACT_REPLY;
            end
         end
         FLG_FINACK: begin
            if (resend_ff) begin
               res_exec.out_seq      = seq_ff;
               res_exec.out_ack      = ack_ff;
               res_exec.out_dst_ip   = dst_ip_ff;
               res_exec.out_src_port = sport_ff;
               res_exec.out_dst_port = dst_port_ff;
               res_exec.out_flags    = FLG_FINACK;
               res_exec.action       = ACT_REPLY;
               wr.state_we           = 1'b1;
               wr.conn_state         = CS_CLOSED;
            end else begin
               res_exec.out_flags = FLG_ACK;
               wr.expect_we       = 1'b1;
               wr.own_we          = 1'b1;
               res_exec.action    = (entry.conn_state == CS_CLOSED) ? ACT_ACK_CLOSE
                                                                    : ACT_FIN_PASS;
            end
         end
         default: ;
      endcase

      // no reply: only the entry number survives
      if (res_exec.action == ACT_NONE) begin
         res_exec = '0;
      end
      res_exec.conn_index = idx_ext[2:0];

      if (state_ff != ST_EXEC) begin
         wr.peer_we   = 1'b0;
         wr.expect_we = 1'b0;
         wr.own_we    = 1'b0;
         wr.state_we  = 1'b0;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      free_seen_in = free_seen_ff;
      free_idx_in  = free_idx_ff;
      res_in       = res_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ptr_in       = '0;
            free_seen_in = 1'b0;
            if (!resend_ff && ((dst_ip_ff != local_ip_ff) ||
                               (dst_port_ff != local_port_ff))) begin
               // drop: empty result
               res_in   = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (key_hit) begin
               state_in = ST_EXEC;
            end else begin
               if (!free_seen_ff && (entry.conn_state == CS_CLOSED)) begin
                  free_seen_in = 1'b1;
                  free_idx_in  = ptr_ff;
               end
               if (ptr_last) begin
                  if (free_seen_ff) begin
                     ptr_in   = free_idx_ff;
                     state_in = ST_EXEC;
                  end else if (entry.conn_state == CS_CLOSED) begin
                     state_in = ST_EXEC;
                  end else begin
                     res_in   = '0;
                     state_in = ST_OUT;
                  end
               end else begin
                  ptr_in = IDX_W'(ptr_ff + 1'b1);
               end
            end
         end
         ST_EXEC: begin
            res_in   = res_exec;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_seen_ff <= free_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      free_idx_ff <= free_idx_in;
      res_ff      <= res_in;
   end

   // ---------------------------------------------------------------- response
   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_action           = res_ff.action;
   assign rsp_conn_index       = res_ff.conn_index;
   assign rsp_out_flags        = res_ff.out_flags;
   assign rsp_out_seq          = res_ff.out_seq;
   assign rsp_out_ack          = res_ff.out_ack;
   assign rsp_out_dst_ip       = res_ff.out_dst_ip;
   assign rsp_out_src_port     = res_ff.out_src_port;
   assign rsp_out_dst_port     = res_ff.out_dst_port;
   assign rsp_deliver_data     = res_ff.deliver_data;
   assign rsp_out_header_words = res_ff.out_header_words;

   // ---------------------------------------------------------------- checks
   a_accept_starts_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CHECK))
      else $error("accepted request did not enter the filter cycle");

   a_no_reply_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_NONE)) |->
         ((rsp_out_flags == FLG_NONE) && !rsp_deliver_data && (rsp_out_seq == '0)))
      else $error("empty result carries reply fields");

   a_deliver_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_deliver_data) |->
         ((rsp_action == ACT_REPLY) || (rsp_action == ACT_ACK_STRIP)))
      else $error("data delivery without an ACK reply");

   a_table_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      (wr.peer_we || wr.expect_we || wr.own_we || wr.state_we) |->
         (state_ff == ST_EXEC))
      else $error("table written outside the execute cycle");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_valid) && $past(rsp_stall) && !$past(reset)) |->
         (rsp_valid && $stable(res_ff)))
      else $error("stalled result changed");

endmodule
